[rtl/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and key functions of the linear-probe hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

	localparam int SLOTS     = 16;
	localparam int KEY_CHARS = 8;

	localparam int KEY_W    = 64;
	localparam int VALUE_W  = 64;
	localparam int MODE_W   = 1;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;

	localparam int IN_DATA_W  = ((KEY_W + VALUE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((VALUE_W + SLOT_W + 7) / 8) * 8;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int HASH_WEIGHT = 31;
	localparam int HASH_MAX    = 255 * HASH_WEIGHT * KEY_CHARS;
	localparam int HASH_W      = $clog2(HASH_MAX + 1);

	// floor(h / SLOTS) == (h * RECIP_K) >> RECIP_SH for every HASH_W-bit h
	localparam int     RECIP_SH = HASH_W + IDX_W;
	localparam int     RECIP_W  = HASH_W + 1;
	localparam int     PROD_W   = HASH_W + RECIP_W;
	localparam longint RECIP    = ((longint'(1) << RECIP_SH) + SLOTS - 1) / SLOTS;
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

	localparam bit SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

	localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic               occ;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	// keep bytes up to the first zero byte, at most KEY_CHARS of them
	function automatic logic [KEY_W-1:0] key_norm(input logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] res;
		logic             alive;
		res   = '0;
		alive = 1'b1;
		for (int p = 0; p < KEY_CHARS; p++) begin
			if (raw[8*p +: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				res[8*p +: 8] = raw[8*p +: 8];
			end
		end
		return res;
	endfunction

	// sum of char * (31 xor position); bytes after the end are already zero
	function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] key);
		logic [HASH_W-1:0] h;
		h = '0;
		for (int p = 0; p < KEY_CHARS; p++) begin
			h = h + HASH_W'(HASH_W'(key[8*p +: 8]) * HASH_W'(HASH_WEIGHT ^ p));
		end
		return h;
	endfunction

endpackage

`default_nettype wire

[rtl/linear_probe_hash_table_core.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Key-value table, open addressing with linear probing, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats enter on s_axis: tuser is the mode (insert or lookup),
//   tdata holds the key (low 64 bits) and the value (next 64 bits).
//   One result beat per request leaves on m_axis: tuser is the status,
//   tdata holds the found value and the slot index.
//   The table lives in one synchronous RAM of SLOTS entries (occupied flag,
//   key, value), read one slot per cycle. A request goes from accept
//   through a start step and P = 1..SLOTS probes to the result register;
//   with a slot count that is not a power of two, a quotient and a remainder
//   step reduce the hash first. A full-table insert skips the probes.
//   The next request is taken once the previous one has reached the
//   output register, which holds the result while m_axis_tready is low.
//   After reset the block clears the RAM, one slot per cycle, with
//   s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lpht_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // key, value
	input  logic [lpht_pkg::MODE_W-1:0]     s_axis_tuser,  // mode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lpht_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // found_value, slot_index, pad
	output logic [lpht_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
	import lpht_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_REDUCE = 6'b000100,
		S_START  = 6'b001000,
		S_PROBE  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    clr_q;
	logic                step_q;
	logic [IDX_W-1:0]    n_q;
	logic [CNT_W-1:0]    count_q;
	logic                m_valid_q;

	logic [MODE_W-1:0]   mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  value_q;
	logic [HASH_W-1:0]   rem_q;
	logic [HASH_W-1:0]   quo_q;
	logic [IDX_W-1:0]    idx_q;
	status_t             res_status_q;
	logic [VALUE_W-1:0]  res_value_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [STATUS_W-1:0] m_user_q;

	entry_t              mem [SLOTS];
	entry_t              rd_q;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	entry_t              wr_data;
	logic [IDX_W-1:0]    rd_addr;

	logic                in_acc;
	logic [KEY_W-1:0]    in_key;
	logic [HASH_W-1:0]   in_hash;
	logic                tbl_full;
	logic [IDX_W-1:0]    idx_nxt;
	logic                is_ins;
	logic                slot_free;
	logic                key_hit;
	logic                last_probe;
	logic                probe_end;
	logic [PROD_W-1:0]   prod;
	logic [HASH_W-1:0]   rem_nxt;
	logic                out_load;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_key        = key_norm(s_axis_tdata[KEY_W-1:0]);
	assign in_hash       = key_hash(in_key);
	assign tbl_full      = (count_q == CNT_W'(SLOTS));

	assign idx_nxt    = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign is_ins     = (mode_q == MODE_INSERT);
	assign slot_free  = !rd_q.occ;
	assign key_hit    = rd_q.occ && (rd_q.key == key_q);
	assign last_probe = (n_q == IDX_W'(SLOTS - 1));
	assign probe_end  = slot_free || (!is_ins && key_hit) || last_probe;

	// hash mod SLOTS: reciprocal multiply, then multiply back and subtract
	assign prod    = PROD_W'(rem_q) * PROD_W'(RECIP_K);
	assign rem_nxt = rem_q - HASH_W'(quo_q * HASH_W'(SLOTS));

	assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '{occ: 1'b1, key: key_q, value: value_q};
		rd_addr = idx_q;
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == S_PROBE) begin
			wr_en   = is_ins && slot_free;
			rd_addr = idx_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			step_q    <= 1'b0;
			n_q       <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser == MODE_INSERT && tbl_full) begin
							state_q <= S_DONE;
						end else if (SLOTS_POW2) begin
							state_q <= S_START;
						end else begin
							step_q  <= 1'b0;
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					step_q <= 1'b1;
					if (step_q) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					n_q     <= '0;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					n_q <= n_q + 1'b1;
					if (probe_end) begin
						state_q <= S_DONE;
						if (is_ins && slot_free) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q       <= s_axis_tuser;
			key_q        <= in_key;
			value_q      <= s_axis_tdata[KEY_W +: VALUE_W];
			rem_q        <= in_hash;
			idx_q        <= in_hash[IDX_W-1:0];
			res_status_q <= ST_FULL;
			res_value_q  <= '0;
			res_slot_q   <= '0;
		end
		if (state_q == S_REDUCE) begin
			if (!step_q) begin
				quo_q <= HASH_W'(prod >> RECIP_SH);
			end else begin
				idx_q <= rem_nxt[IDX_W-1:0];
			end
		end
		if (state_q == S_PROBE) begin
			if (!probe_end) begin
				idx_q <= idx_nxt;
			end else if (is_ins) begin
				res_status_q <= slot_free ? ST_INSERTED : ST_FULL;
				res_value_q  <= '0;
				res_slot_q   <= slot_free ? SLOT_W'(idx_q) : '0;
			end else begin
				res_status_q <= key_hit ? ST_FOUND : ST_NOT_FOUND;
				res_value_q  <= key_hit ? rd_q.value : '0;
				res_slot_q   <= key_hit ? SLOT_W'(idx_q) : '0;
			end
		end
		if (out_load) begin
			m_data_q <= OUT_DATA_W'({res_slot_q, res_value_q});
			m_user_q <= res_status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

[rtl/lpht_checker.sv]
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic [lpht_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic [lpht_pkg::MODE_W-1:0]     s_axis_tuser,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [lpht_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [lpht_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import lpht_pkg::*;

	// one request in flight: no beat right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while previous one in flight");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata[VALUE_W-1:0] == '0)
		else $error("found_value nonzero without a match");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_FULL)
		|-> m_axis_tdata[VALUE_W +: SLOT_W] == '0)
		else $error("slot_index nonzero on miss or full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (.*);

`default_nettype wire
